@@ rtl/timestamp_timebase_rescale_macros.svh @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_TIMEBASE_RESCALE_MACROS_SVH
`define TIMESTAMP_TIMEBASE_RESCALE_MACROS_SVH
`ifndef SYNTH
`define TTR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttr assertion failed");
`define TTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttr assertion failed");
`else
`define TTR_ASSERT_SAME(label, clk, rst, ante, cons)
`define TTR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ttr_pkg.sv @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler package
// Shared command, status and register codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ttr_pkg;
   localparam int unsigned TS_W = 64;
   localparam int unsigned BASE_W = 32;
   localparam int unsigned CNT_W = 8;
   localparam logic [CNT_W-1:0] DIV_WORD_STEPS = 8'd32;
   localparam logic [CNT_W-1:0] DIV_WIDE_STEPS = 8'd128;

   localparam logic [2:0] CSR_SRC_NUM = 3'd0;
   localparam logic [2:0] CSR_SRC_DEN = 3'd1;
   localparam logic [2:0] CSR_DST_NUM = 3'd2;
   localparam logic [2:0] CSR_DST_DEN = 3'd3;
   localparam logic [2:0] CSR_ROUND = 3'd4;

   typedef enum logic [1:0] {
      RND_ZERO,
      RND_FLOOR,
      RND_CEIL,
      RND_NEAREST
   } rnd_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_GCD,
      OP_CAP_GCD,
      OP_DIV,
      OP_CAP_QUO,
      OP_MUL,
      OP_CAP_MUL,
      OP_PART,
      OP_ACC,
      OP_WIDE_DIV,
      OP_ROUND,
      OP_FINISH,
      OP_FAIL
   } op_type;

   typedef struct packed {
      op_type op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic base_zero;
      logic gcd_done;
      logic gcd_one;
      logic div_done;
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/ttr_datapath.sv @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler datapath
// Configuration registers, binary gcd unit, serial divider, shared 32x32
// multiplier with 128-bit accumulator, rounding and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ttr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   input  logic signed [63:0]  req_timestamp_in,
   input  ttr_pkg::cmd_type    cmd,
   output ttr_pkg::stat_type   stat,
   output logic signed [63:0]  rsp_timestamp_out,
   output logic                rsp_status
);
   logic [31:0] sn_ff, sd_ff, dn_ff, dd_ff;
   logic [1:0]  mode_ff;
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff;
   logic [31:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [4:0]  gk_ff, gk_in;
   logic [31:0] gres;
   logic [31:0] g1_ff, g2_ff;
   logic [31:0] mna_ff, mnb_ff, dva_ff, dvb_ff;
   logic [63:0] muln_ff, divisor_ff;
   logic [63:0] mp_ff;
   logic [31:0] mul_a, mul_b;
   logic [127:0] acc_ff, acc_add;
   logic [127:0] dq_ff, dq_in;
   logic [63:0] dr_ff, dr_in, dvs_ff, dvs_in;
   logic [ttr_pkg::CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [64:0] trial;
   logic        ge;
   logic [31:0] div_num, div_den;
   logic [63:0] half_rest, ql, qmag;
   logic        up, fit;
   logic [63:0] ts_u;

   assign ts_u = req_timestamp_in;
   assign mag_in = ts_u[63] ? (~ts_u + 64'd1) : ts_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         sn_ff <= 32'd1;
         sd_ff <= 32'd1;
         dn_ff <= 32'd1;
         dd_ff <= 32'd1;
         mode_ff <= 2'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ttr_pkg::CSR_SRC_NUM: sn_ff <= csr_write_data;
            ttr_pkg::CSR_SRC_DEN: sd_ff <= csr_write_data;
            ttr_pkg::CSR_DST_NUM: dn_ff <= csr_write_data;
            ttr_pkg::CSR_DST_DEN: dd_ff <= csr_write_data;
            ttr_pkg::CSR_ROUND: mode_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   assign gres = (ga_ff | gb_ff) << gk_ff;
   assign stat.base_zero = (sn_ff == 32'd0) || (sd_ff == 32'd0) ||
                           (dn_ff == 32'd0) || (dd_ff == 32'd0);
   assign stat.gcd_done = (ga_ff == 32'd0) || (gb_ff == 32'd0);
   assign stat.gcd_one = (gres == 32'd1);
   assign stat.div_done = (dcnt_ff == '0);

   always_comb begin
      ga_in = ga_ff;
      gb_in = gb_ff;
      gk_in = gk_ff;
      if (cmd.op == ttr_pkg::OP_GCD) begin
         gk_in = 5'd0;
         unique case (cmd.sel)
            2'd0: begin ga_in = sn_ff; gb_in = sd_ff; end
            2'd1: begin ga_in = dn_ff; gb_in = dd_ff; end
            2'd2: begin ga_in = sn_ff; gb_in = dn_ff; end
            default: begin ga_in = dd_ff; gb_in = sd_ff; end
         endcase
      end else if (!stat.gcd_done) begin
         priority if (!ga_ff[0] && !gb_ff[0]) begin
            ga_in = ga_ff >> 1;
            gb_in = gb_ff >> 1;
            gk_in = gk_ff + 5'd1;
         end else if (!ga_ff[0]) begin
            ga_in = ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_in = gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_in = (ga_ff - gb_ff) >> 1;
         end else begin
            gb_in = (gb_ff - ga_ff) >> 1;
         end
      end
   end

   always_comb begin
      unique case (cmd.sel)
         2'd0: div_num = sn_ff;
         2'd1: div_num = dd_ff;
         2'd2: div_num = dn_ff;
         default: div_num = sd_ff;
      endcase
      div_den = cmd.sel[0] ? g2_ff : g1_ff;
   end

   assign trial = {dr_ff, dq_ff[127]};
   assign ge = (trial >= {1'b0, dvs_ff});

   always_comb begin
      dq_in = dq_ff;
      dr_in = dr_ff;
      dvs_in = dvs_ff;
      dcnt_in = dcnt_ff;
      priority if (cmd.op == ttr_pkg::OP_DIV) begin
         dq_in = {div_num, 96'd0};
         dr_in = 64'd0;
         dvs_in = {32'd0, div_den};
         dcnt_in = ttr_pkg::DIV_WORD_STEPS;
      end else if (cmd.op == ttr_pkg::OP_WIDE_DIV) begin
         dq_in = acc_ff;
         dr_in = 64'd0;
         dvs_in = divisor_ff;
         dcnt_in = ttr_pkg::DIV_WIDE_STEPS;
      end else if (cmd.op == ttr_pkg::OP_ROUND) begin
         dq_in = dq_ff + {127'd0, up};
      end else if (dcnt_ff != '0) begin
         dq_in = {dq_ff[126:0], ge};
         dr_in = ge ? 64'(trial - {1'b0, dvs_ff}) : trial[63:0];
         dcnt_in = dcnt_ff - 8'd1;
      end
   end

   always_comb begin
      if (cmd.op == ttr_pkg::OP_PART) begin
         mul_a = cmd.sel[1] ? mag_ff[63:32] : mag_ff[31:0];
         mul_b = cmd.sel[0] ? muln_ff[63:32] : muln_ff[31:0];
      end else if (cmd.sel[0]) begin
         mul_a = dva_ff;
         mul_b = dvb_ff;
      end else begin
         mul_a = mna_ff;
         mul_b = mnb_ff;
      end
   end

   always_comb begin
      unique case ({1'b0, cmd.sel[1]} + {1'b0, cmd.sel[0]})
         2'd0: acc_add = {64'd0, mp_ff};
         2'd1: acc_add = {32'd0, mp_ff, 32'd0};
         default: acc_add = {mp_ff, 64'd0};
      endcase
   end

   assign half_rest = divisor_ff - dr_ff;
   always_comb begin
      unique case (ttr_pkg::rnd_type'(mode_ff))
         ttr_pkg::RND_FLOOR: up = neg_ff && (dr_ff != 64'd0);
         ttr_pkg::RND_CEIL: up = !neg_ff && (dr_ff != 64'd0);
         ttr_pkg::RND_NEAREST: up = (dr_ff > half_rest) ||
                                    ((dr_ff == half_rest) && dq_ff[0]);
         default: up = 1'b0;
      endcase
   end

   assign ql = dq_ff[63:0];
   assign fit = (dq_ff[127:64] == 64'd0) &&
                (neg_ff ? (ql <= 64'h8000_0000_0000_0000) : !ql[63]);
   assign qmag = neg_ff ? (~ql + 64'd1) : ql;

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ga_ff <= ga_in;
      gb_ff <= gb_in;
      gk_ff <= gk_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      dvs_ff <= dvs_in;
      unique case (cmd.op)
         ttr_pkg::OP_LOAD: begin
            mag_ff <= mag_in;
            neg_ff <= ts_u[63];
            acc_ff <= 128'd0;
         end
         ttr_pkg::OP_CAP_GCD: begin
            if (cmd.sel[0]) g2_ff <= gres;
            else g1_ff <= gres;
         end
         ttr_pkg::OP_CAP_QUO: begin
            unique case (cmd.sel)
               2'd0: mna_ff <= dq_ff[31:0];
               2'd1: mnb_ff <= dq_ff[31:0];
               2'd2: dva_ff <= dq_ff[31:0];
               default: dvb_ff <= dq_ff[31:0];
            endcase
         end
         ttr_pkg::OP_MUL, ttr_pkg::OP_PART: mp_ff <= mul_a * mul_b;
         ttr_pkg::OP_CAP_MUL: begin
            if (cmd.sel[0]) divisor_ff <= mp_ff;
            else muln_ff <= mp_ff;
         end
         ttr_pkg::OP_ACC: acc_ff <= acc_ff + acc_add;
         ttr_pkg::OP_FINISH: begin
            rsp_timestamp_out <= fit ? qmag : 64'd0;
            rsp_status <= !fit;
         end
         ttr_pkg::OP_FAIL: begin
            rsp_timestamp_out <= 64'd0;
            rsp_status <= 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/ttr_ctrl.sv @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler controller
// Sequences base checks, gcds, divisions, products and the wide division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ttr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ttr_pkg::stat_type stat,
   output ttr_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_GCD_GO, S_GCD_WAIT, S_DIV_GO, S_DIV_WAIT,
      S_MUL_GO, S_MUL_CAP, S_PART_GO, S_PART_ACC, S_WIDE_GO, S_WIDE_WAIT,
      S_ROUND, S_OUT_OK, S_OUT_FAIL
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd.op = ttr_pkg::OP_IDLE;
      cmd.sel = sel_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = ttr_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            sel_in = 2'd0;
            state_in = stat.base_zero ? S_OUT_FAIL : S_GCD_GO;
         end
         S_GCD_GO: begin
            cmd.op = ttr_pkg::OP_GCD;
            state_in = S_GCD_WAIT;
         end
         S_GCD_WAIT: begin
            if (stat.gcd_done) begin
               if (!sel_ff[1]) begin
                  sel_in = sel_ff + 2'd1;
                  state_in = stat.gcd_one ? S_GCD_GO : S_OUT_FAIL;
               end else begin
                  cmd.op = ttr_pkg::OP_CAP_GCD;
                  sel_in = sel_ff + 2'd1;
                  state_in = sel_ff[0] ? S_DIV_GO : S_GCD_GO;
               end
            end
         end
         S_DIV_GO: begin
            cmd.op = ttr_pkg::OP_DIV;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.op = ttr_pkg::OP_CAP_QUO;
               sel_in = sel_ff + 2'd1;
               state_in = (sel_ff == 2'd3) ? S_MUL_GO : S_DIV_GO;
            end
         end
         S_MUL_GO: begin
            cmd.op = ttr_pkg::OP_MUL;
            state_in = S_MUL_CAP;
         end
         S_MUL_CAP: begin
            cmd.op = ttr_pkg::OP_CAP_MUL;
            sel_in = sel_ff[0] ? 2'd0 : 2'd1;
            state_in = sel_ff[0] ? S_PART_GO : S_MUL_GO;
         end
         S_PART_GO: begin
            cmd.op = ttr_pkg::OP_PART;
            state_in = S_PART_ACC;
         end
         S_PART_ACC: begin
            cmd.op = ttr_pkg::OP_ACC;
            sel_in = sel_ff + 2'd1;
            state_in = (sel_ff == 2'd3) ? S_WIDE_GO : S_PART_GO;
         end
         S_WIDE_GO: begin
            cmd.op = ttr_pkg::OP_WIDE_DIV;
            state_in = S_WIDE_WAIT;
         end
         S_WIDE_WAIT: begin
            if (stat.div_done) state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op = ttr_pkg::OP_ROUND;
            state_in = S_OUT_OK;
         end
         S_OUT_OK: begin
            if (out_free) begin
               cmd.op = ttr_pkg::OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OUT_FAIL: begin
            if (out_free) begin
               cmd.op = ttr_pkg::OP_FAIL;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

@@ rtl/timestamp_timebase_rescale.sv @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler
// Rescales a signed 64-bit tick count between two rational time bases.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_timestamp_in
// rsp       out        rsp_valid / rsp_stall   rsp_timestamp_out, rsp_status
// csr       in         csr_write_enable        csr_index, csr_write_data
//
// One item at a time. After acceptance the controller runs four binary gcds,
// four word divisions, two products, four partial products with accumulation,
// the 128-bit division and rounding, then raises rsp_valid; invalid bases end early in an error response.
// The bit-serial divider and the gcd unit set the run time.
// Reset is synchronous; bases reset to 1/1 and rounding to toward zero.
// A result waiting under rsp_stall does not block acceptance of the next item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_timebase_rescale_macros.svh"
module timestamp_timebase_rescale (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_timestamp_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_timestamp_out,
   output logic               rsp_status,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   ttr_pkg::cmd_type  cmd;
   ttr_pkg::stat_type stat;

   ttr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_timestamp_in  (req_timestamp_in),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_timestamp_out (rsp_timestamp_out),
      .rsp_status        (rsp_status)
   );

   `TTR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `TTR_ASSERT_NEXT(a_no_instant_result, clock, reset, req_valid && !req_stall, !$rose(rsp_valid))
   `TTR_ASSERT_SAME(a_error_zero, clock, reset, rsp_valid && rsp_status, rsp_timestamp_out == 64'sd0)
endmodule
`default_nettype wire

@@ bench/timestamp_timebase_rescale_test.sv @@
// ----------------------------------------------------------------------------
// Timestamp time-base rescaler testbench
// Drives timestamps through several base and rounding settings, predicts each
// rescaled result with exact 128-bit arithmetic and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module timestamp_timebase_rescale_test;
   localparam int DRAIN_CYCLES = 1200;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [63:0] timestamp_out;
      logic               status;
   } rescale_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [63:0] req_timestamp_in = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_timestamp_out;
   logic               rsp_status;
   logic               csr_write_enable = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   logic [31:0] base_sn, base_sd, base_dn, base_dd;
   ttr_pkg::rnd_type round_sel;
   rescale_result_type pending_results[$];
   int  failures = 0;
   int  idle_cycles = 0;
   bit  idling_on = 1'b1;
   int  hold_off = 0;

   timestamp_timebase_rescale u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rescale_result_type rescale(logic [63:0] x);
      rescale_result_type res;
      logic          neg;
      logic [63:0]   mag, mul_n, divisor, rem, half_rest;
      logic [31:0]   g1, g2;
      logic [127:0]  quo;
      logic          up;
      res = '{timestamp_out: '0, status: 1'b1};
      neg = x[63];
      mag = neg ? -x : x;
      up = 1'b0;
      if (base_sn == 0 || base_sd == 0 || gcd_of(base_sn, base_sd) != 1 ||
          base_dn == 0 || base_dd == 0 || gcd_of(base_dn, base_dd) != 1)
         return res;
      g1 = gcd_of(base_sn, base_dn);
      g2 = gcd_of(base_dd, base_sd);
      mul_n = 64'(base_sn / g1) * 64'(base_dd / g2);
      divisor = 64'(base_dn / g1) * 64'(base_sd / g2);
      quo = (128'(mag) * 128'(mul_n)) / 128'(divisor);
      rem = 64'((128'(mag) * 128'(mul_n)) % 128'(divisor));
      case (round_sel)
         ttr_pkg::RND_FLOOR: up = neg && rem != 0;
         ttr_pkg::RND_CEIL: up = !neg && rem != 0;
         ttr_pkg::RND_NEAREST: begin
            half_rest = divisor - rem;
            up = (rem > half_rest) || (rem == half_rest && quo[0]);
         end
         default: up = 1'b0;
      endcase
      if (up) quo = quo + 1;
      if (quo[127:64] != 0) return res;
      if (neg ? (quo[63:0] > 64'h8000000000000000) : quo[63]) return res;
      res.timestamp_out = neg ? -quo[63:0] : quo[63:0];
      res.status = 1'b0;
      return res;
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         ttr_pkg::CSR_SRC_NUM: base_sn = data;
         ttr_pkg::CSR_SRC_DEN: base_sd = data;
         ttr_pkg::CSR_DST_NUM: base_dn = data;
         ttr_pkg::CSR_DST_DEN: base_dd = data;
         ttr_pkg::CSR_ROUND: round_sel = ttr_pkg::rnd_type'(data[1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_bases(logic [31:0] sn, logic [31:0] sd, logic [31:0] dn,
                            logic [31:0] dd, ttr_pkg::rnd_type mode);
      release_req();
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(ttr_pkg::CSR_SRC_NUM, sn);
      write_csr(ttr_pkg::CSR_SRC_DEN, sd);
      write_csr(ttr_pkg::CSR_DST_NUM, dn);
      write_csr(ttr_pkg::CSR_DST_DEN, dd);
      write_csr(ttr_pkg::CSR_ROUND, 32'(mode));
   endtask

   task automatic send_timestamp(logic [63:0] ts);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_timestamp_in <= ts;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(rescale(ts));
   endtask

   function automatic logic [63:0] random_timestamp();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: v = 64'($signed(v[15:0]));
         1: v = 64'($signed(v[39:0]));
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] random_base();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 16);
         1: return $urandom_range(1, 100000);
         2: return 32'hFFFFFFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_identity_extremes();
      logic [63:0] edge_values[8] = '{64'h0, 64'h1, 64'hFFFFFFFFFFFFFFFF,
         64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000, 64'h8000000000000001,
         64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA};
      foreach (edge_values[i]) send_timestamp(edge_values[i]);
   endtask

   task automatic test_rounding_modes();
      logic [63:0] vals[6] = '{64'd5, -64'd5, 64'd7, -64'd7, 64'd4, -64'd4};
      for (int m = 0; m < 4; m++) begin
         set_bases(32'd1, 32'd1, 32'd2, 32'd1, ttr_pkg::rnd_type'(m));
         foreach (vals[i]) send_timestamp(vals[i]);
         set_bases(32'd1, 32'd1, 32'd3, 32'd1, ttr_pkg::rnd_type'(m));
         send_timestamp(64'd4);
         send_timestamp(-64'd5);
      end
   endtask

   task automatic test_invalid_and_overflow();
      set_bases(32'd0, 32'd1, 32'd1, 32'd1, ttr_pkg::RND_ZERO);
      send_timestamp(64'd9);
      set_bases(32'd4, 32'd6, 32'd1, 32'd1, ttr_pkg::RND_ZERO);
      send_timestamp(64'd9);
      set_bases(32'd1, 32'd1, 32'd1, 32'd0, ttr_pkg::RND_ZERO);
      send_timestamp(64'd9);
      set_bases(32'hFFFFFFFF, 32'd1, 32'd1, 32'hFFFFFFFE, ttr_pkg::RND_CEIL);
      send_timestamp(64'h7FFFFFFFFFFFFFFF);
      send_timestamp(64'h8000000000000000);
      send_timestamp(64'd3);
      set_bases(32'd1, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'd1, ttr_pkg::RND_NEAREST);
      send_timestamp(64'h7FFFFFFFFFFFFFFF);
      send_timestamp(64'h8000000000000000);
   endtask

   task automatic test_backpressure();
      set_bases(32'd3, 32'd7, 32'd5, 32'd11, ttr_pkg::RND_FLOOR);
      hold_off = 2000;
      for (int i = 0; i < 6; i++) send_timestamp(random_timestamp());
   endtask

   task automatic test_random_rescale(int n_items);
      for (int i = 0; i < n_items; i++) begin
         if (i % 60 == 0) begin
            if ($urandom_range(0, 5) == 0)
               set_bases(random_base(), random_base(), random_base(),
                         random_base(), ttr_pkg::rnd_type'($urandom_range(0, 3)));
            else
               set_bases(32'd1000 / gcd_of(32'd1000, $urandom_range(1, 1000)),
                         $urandom_range(1, 1) , 32'd1, $urandom_range(1, 90000),
                         ttr_pkg::rnd_type'($urandom_range(0, 3)));
         end
         if (i == n_items - 120) idling_on = 1'b0;
         send_timestamp(random_timestamp());
      end
   endtask

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0)
         rsp_stall <= 1'b1;
      else if (!rsp_stall || $urandom_range(0, 2) == 0 || !idling_on)
         rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      rescale_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_timestamp_out !== want.timestamp_out) begin
               $error("timestamp_out expected %0d actual %0d",
                      want.timestamp_out, rsp_timestamp_out);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      base_sn = 1;
      base_sd = 1;
      base_dn = 1;
      base_dd = 1;
      round_sel = ttr_pkg::RND_ZERO;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_identity_extremes();
      test_rounding_modes();
      test_invalid_and_overflow();
      test_backpressure();
      test_random_rescale(780);
      release_req();
      wait (pending_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
